FILE: design/decentralized_adam_update_macros.svh
// Assertion macros for the decentralized Adam update block.
// Used by the top level only; depends on nothing else.
`ifndef DECENTRALIZED_ADAM_UPDATE_MACROS_SVH
`define DECENTRALIZED_ADAM_UPDATE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DAU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define DAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/dau_pkg.sv
// Shared constants, types and saturation helpers of the Adam update block.
// Used by dau_div and decentralized_adam_update; depends on nothing.
package dau_pkg;

    localparam int MAX_NODES  = 16;
    localparam int VECTOR_LEN = 256;
    localparam int NODE_W     = 4;
    localparam int ELEM_W     = 8;
    localparam int ADDR_W     = NODE_W + ELEM_W;
    localparam int DEPTH      = MAX_NODES * VECTOR_LEN;
    localparam int DVD_W      = 48;
    localparam int DVS_W      = 25;

    localparam logic [1:0] MODE_INIT      = 2'd0;
    localparam logic [1:0] MODE_ITERATION = 2'd1;
    localparam logic [1:0] MODE_GRADIENT  = 2'd2;
    localparam logic [1:0] MODE_CONSENSUS = 2'd3;

    localparam logic [2:0] REG_BETA_FIRST   = 3'd0;
    localparam logic [2:0] REG_BETA_SECOND  = 3'd1;
    localparam logic [2:0] REG_EPSILON_TERM = 3'd2;
    localparam logic [2:0] REG_STEP_SIZE    = 3'd3;
    localparam logic [2:0] REG_NODE_COUNT   = 3'd4;

    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [DVS_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DVD_W-1:0]   quotient;
    } t_div_rsp;

    function automatic logic signed [31:0] f_sat32(input logic signed [49:0] x);
        logic signed [31:0] y;
        if (x > 50'sh7FFFFFFF) begin
            y = 32'sh7FFFFFFF;
        end else if (x < -50'sh80000000) begin
            y = 32'sh80000000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    // Round half up, drop 16 fraction bits, saturate.
    function automatic logic signed [31:0] f_round_sat(input logic signed [49:0] x);
        logic signed [49:0] t;
        t = (x + 50'sd32768) >>> 16;
        return f_sat32(t);
    endfunction

    // Apply a sign to an unsigned quotient and saturate.
    function automatic logic signed [31:0] f_sat_quo(input logic neg,
                                                     input logic [DVD_W-1:0] q);
        logic signed [31:0] y;
        if (!neg) begin
            y = (q > 48'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(q[31:0]);
        end else begin
            y = (q > 48'h80000000) ? 32'sh80000000 : $signed(-q[31:0]);
        end
        return y;
    endfunction

endpackage

FILE: design/dau_div.sv
// Restoring divider, one quotient bit per cycle, shared by every division.
// Depends on dau_pkg for the request and response structs.
module dau_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dau_pkg::t_div_req i_req,
    output dau_pkg::t_div_rsp o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [5:0]                    r_cnt;
    logic [dau_pkg::DVD_W-1:0]     r_quo;
    logic [dau_pkg::DVS_W-1:0]     r_rem;
    logic [dau_pkg::DVS_W-1:0]     r_dvs;
    logic [dau_pkg::DVS_W:0]       shifted;
    logic [dau_pkg::DVS_W:0]       trial;

    assign shifted = {r_rem, r_quo[dau_pkg::DVD_W-1]};
    assign trial   = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(dau_pkg::DVD_W);
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                if (!trial[dau_pkg::DVS_W]) begin
                    r_rem <= trial[dau_pkg::DVS_W-1:0];
                    r_quo <= {r_quo[dau_pkg::DVD_W-2:0], 1'b1};
                end else begin
                    r_rem <= shifted[dau_pkg::DVS_W-1:0];
                    r_quo <= {r_quo[dau_pkg::DVD_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

FILE: design/decentralized_adam_update.sv
// Decentralized Adam update with init, new iteration, consensus over N nodes and gradient
// modes (gradient waits up to three times on the 48-step dau_div and runs a 24-step square root;
// each bias correction is skipped before the first iteration, saving its division).
// One beat is worked on at a time; the next can be taken in the cycle after the result is loaded.
// Synchronous active-low reset; after it a pass over every address zeroes both moment
// memories while no beat is taken. Weight memories hold no value until init.
module decentralized_adam_update (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: node_index[3:0], element_index[11:4], value_in[43:12], zero fill
    input  logic [47:0] s_axis_tdata,
    // tuser: mode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: result_node[3:0], result_element[11:4], result_value[43:12], zero fill
    output logic [47:0] m_axis_tdata,
    // tuser: result_kind[1:0]
    output logic [1:0]  m_axis_tuser
);

    `include "decentralized_adam_update_macros.svh"

    localparam logic [4:0] ST_CLEAR = 5'd0;
    localparam logic [4:0] ST_IDLE  = 5'd1;
    localparam logic [4:0] ST_INIT  = 5'd2;
    localparam logic [4:0] ST_POW1  = 5'd3;
    localparam logic [4:0] ST_POW2  = 5'd4;
    localparam logic [4:0] ST_POW3  = 5'd5;
    localparam logic [4:0] ST_CRD   = 5'd6;
    localparam logic [4:0] ST_CACC  = 5'd7;
    localparam logic [4:0] ST_CDS   = 5'd8;
    localparam logic [4:0] ST_CDW   = 5'd9;
    localparam logic [4:0] ST_CWR   = 5'd10;
    localparam logic [4:0] ST_GRD   = 5'd11;
    localparam logic [4:0] ST_G1    = 5'd12;
    localparam logic [4:0] ST_G2    = 5'd13;
    localparam logic [4:0] ST_G3    = 5'd14;
    localparam logic [4:0] ST_G4    = 5'd15;
    localparam logic [4:0] ST_G5    = 5'd16;
    localparam logic [4:0] ST_G6    = 5'd17;
    localparam logic [4:0] ST_G7    = 5'd18;
    localparam logic [4:0] ST_G8    = 5'd19;
    localparam logic [4:0] ST_G9    = 5'd20;
    localparam logic [4:0] ST_G10   = 5'd21;
    localparam logic [4:0] ST_SQI   = 5'd22;
    localparam logic [4:0] ST_SQL   = 5'd23;
    localparam logic [4:0] ST_G13   = 5'd24;
    localparam logic [4:0] ST_G14   = 5'd25;
    localparam logic [4:0] ST_G15   = 5'd26;
    localparam logic [4:0] ST_G16   = 5'd27;
    localparam logic [4:0] ST_G17   = 5'd28;
    localparam logic [4:0] ST_FIN   = 5'd29;

    localparam int AW = dau_pkg::ADDR_W;

    logic [4:0]  r_state;
    logic [AW-1:0] r_cnt;
    logic [4:0]  r_cntn;

    logic [15:0] r_beta1, r_beta2, r_eps, r_step;
    logic [4:0]  r_ncount;
    logic [31:0] r_iter;
    logic [16:0] r_bp1, r_bp2;

    logic [1:0]  r_mode;
    logic [dau_pkg::NODE_W-1:0] r_node;
    logic [dau_pkg::ELEM_W-1:0] r_elem;
    logic signed [31:0] r_val;

    logic signed [65:0] r_prod;
    logic signed [49:0] r_acc;
    logic signed [31:0] r_m, r_mh, r_dir, r_delta, r_res;
    logic [30:0] r_gsq, r_v, r_vh;
    logic signed [35:0] r_sum;
    logic [47:0] r_sx, r_sr, r_sb;

    logic        r_ovalid;
    logic [1:0]  r_okind;
    logic [dau_pkg::NODE_W-1:0] r_onode;
    logic [dau_pkg::ELEM_W-1:0] r_oelem;
    logic [31:0] r_ovalue;

    logic [31:0] r_fm_mem [0:dau_pkg::DEPTH-1];
    logic [31:0] r_sm_mem [0:dau_pkg::DEPTH-1];
    logic [31:0] r_nw_mem [0:dau_pkg::DEPTH-1];
    logic [31:0] r_cw_mem [0:dau_pkg::DEPTH-1];
    logic [31:0] r_fm_q, r_sm_q, r_nw_q, r_cw_q;

    logic          fm_we, sm_we, nw_we, cw_we;
    logic [AW-1:0] fm_wa, sm_wa, nw_wa, cw_wa;
    logic [31:0]   fm_wd, sm_wd, nw_wd, cw_wd;
    logic          grd_re, nw_re;
    logic [AW-1:0] idx, loop_addr;

    logic signed [32:0] mul_a, mul_b;
    dau_pkg::t_div_req div_req;
    dau_pkg::t_div_rsp div_rsp;

    logic        accept;
    logic        fin_load;
    logic [16:0] d1, d2;
    logic [31:0] abs_m, abs_mh;
    logic [35:0] abs_sum;
    logic [24:0] den;
    logic [47:0] sq_t;
    logic signed [31:0] m_new, v_new, delta_new, res_new;
    logic [33:0] pow_t;
    logic [4:0]  cnt_next;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    // The output stage takes a new beat once the previous one has left.
    assign fin_load      = (r_state == ST_FIN) && (!r_ovalid || m_axis_tready);
    assign idx           = {r_node, r_elem};
    assign loop_addr     = {r_cnt[dau_pkg::NODE_W-1:0], r_elem};
    assign cnt_next      = r_cnt[4:0] + 5'd1;
    assign d1            = 17'h10000 - r_bp1;
    assign d2            = 17'h10000 - r_bp2;
    assign abs_m         = r_m[31] ? 32'(-r_m) : 32'(r_m);
    assign abs_mh        = r_mh[31] ? 32'(-r_mh) : 32'(r_mh);
    assign abs_sum       = r_sum[35] ? 36'(-r_sum) : 36'(r_sum);
    assign sq_t          = r_sr + r_sb;
    assign pow_t         = r_prod[33:0] + 34'd32768;
    assign m_new         = dau_pkg::f_round_sat(r_acc + $signed(r_prod[49:0]));
    assign v_new         = dau_pkg::f_round_sat(r_acc + $signed(r_prod[49:0]));
    assign delta_new     = dau_pkg::f_round_sat($signed(r_prod[49:0]));
    assign res_new       = dau_pkg::f_sat32(50'(signed'(r_cw_q)) - 50'(r_delta));

    always_comb begin
        den = {1'b0, r_sr[23:0]} + {9'b0, r_eps};
        if (den == 25'd0) begin
            den = 25'd1;
        end
    end

    // Shared multiplier operand select.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_POW1: begin mul_a = {16'b0, r_bp1}; mul_b = {17'b0, r_beta1}; end
            ST_POW2: begin mul_a = {16'b0, r_bp2}; mul_b = {17'b0, r_beta2}; end
            ST_G1:   begin mul_a = 33'(signed'(r_fm_q)); mul_b = {17'b0, r_beta1}; end
            ST_G2:   begin
                mul_a = 33'(r_val);
                mul_b = {16'b0, 17'h10000 - {1'b0, r_beta1}};
            end
            ST_G3:   begin mul_a = 33'(r_val); mul_b = 33'(r_val); end
            ST_G4:   begin mul_a = 33'(signed'(r_sm_q)); mul_b = {17'b0, r_beta2}; end
            ST_G5:   begin
                mul_a = {2'b0, r_gsq};
                mul_b = {16'b0, 17'h10000 - {1'b0, r_beta2}};
            end
            ST_G15:  begin mul_a = 33'(r_dir); mul_b = {17'b0, r_step}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Divider request select.
    always_comb begin
        div_req = '0;
        case (r_state)
            ST_CDS: begin
                div_req.start    = 1'b1;
                div_req.dividend = {12'b0, abs_sum};
                div_req.divisor  = {20'b0, r_cntn};
            end
            ST_G7: begin
                div_req.start    = (d1 != 17'd0);
                div_req.dividend = {abs_m, 16'b0};
                div_req.divisor  = {8'b0, d1};
            end
            ST_G9: begin
                div_req.start    = (d2 != 17'd0);
                div_req.dividend = {1'b0, r_v, 16'b0};
                div_req.divisor  = {8'b0, d2};
            end
            ST_G13: begin
                div_req.start    = 1'b1;
                div_req.dividend = {abs_mh, 16'b0};
                div_req.divisor  = den;
            end
            default: div_req = '0;
        endcase
    end

    // Memory port select.
    always_comb begin
        fm_we = 1'b0; fm_wa = idx; fm_wd = '0;
        sm_we = 1'b0; sm_wa = idx; sm_wd = '0;
        nw_we = 1'b0; nw_wa = idx; nw_wd = r_val;
        cw_we = 1'b0; cw_wa = loop_addr; cw_wd = r_val;
        grd_re = (r_state == ST_GRD);
        nw_re  = (r_state == ST_CRD);
        case (r_state)
            ST_CLEAR: begin
                fm_we = 1'b1; fm_wa = r_cnt;
                sm_we = 1'b1; sm_wa = r_cnt;
            end
            ST_INIT: begin
                fm_we = 1'b1; fm_wa = loop_addr;
                sm_we = 1'b1; sm_wa = loop_addr;
                nw_we = 1'b1; nw_wa = loop_addr;
                cw_we = 1'b1;
            end
            ST_G3:  begin fm_we = 1'b1; fm_wd = m_new; end
            ST_G6:  begin sm_we = 1'b1; sm_wd = v_new[31] ? 32'd0 : v_new; end
            ST_G17: begin nw_we = 1'b1; nw_wd = res_new; end
            ST_CWR: begin cw_we = 1'b1; cw_wd = r_res; end
            default: begin fm_we = 1'b0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (fm_we) r_fm_mem[fm_wa] <= fm_wd;
        if (sm_we) r_sm_mem[sm_wa] <= sm_wd;
        if (nw_we) r_nw_mem[nw_wa] <= nw_wd;
        if (cw_we) r_cw_mem[cw_wa] <= cw_wd;
        if (grd_re) begin
            r_fm_q <= r_fm_mem[idx];
            r_sm_q <= r_sm_mem[idx];
            r_cw_q <= r_cw_mem[idx];
        end
        if (nw_re) r_nw_q <= r_nw_mem[loop_addr];
    end

    dau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta1  <= 16'd58982;
            r_beta2  <= 16'd65470;
            r_eps    <= 16'd1;
            r_step   <= 16'd66;
            r_ncount <= 5'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                dau_pkg::REG_BETA_FIRST:   r_beta1  <= i_cfg_data;
                dau_pkg::REG_BETA_SECOND:  r_beta2  <= i_cfg_data;
                dau_pkg::REG_EPSILON_TERM: r_eps    <= i_cfg_data;
                dau_pkg::REG_STEP_SIZE:    r_step   <= i_cfg_data;
                dau_pkg::REG_NODE_COUNT:   r_ncount <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Output stage valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (fin_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_cnt    <= '0;
            r_iter   <= '0;
            r_bp1    <= 17'h10000;
            r_bp2    <= 17'h10000;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (&r_cnt) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_mode <= s_axis_tuser;
                        r_node <= s_axis_tdata[3:0];
                        r_elem <= s_axis_tdata[11:4];
                        r_val  <= $signed(s_axis_tdata[43:12]);
                        r_cnt  <= '0;
                        r_sum  <= '0;
                        if (r_ncount == 5'd0) begin
                            r_cntn <= 5'd1;
                        end else if (r_ncount > 5'(dau_pkg::MAX_NODES)) begin
                            r_cntn <= 5'(dau_pkg::MAX_NODES);
                        end else begin
                            r_cntn <= r_ncount;
                        end
                        case (s_axis_tuser)
                            dau_pkg::MODE_INIT:      r_state <= ST_INIT;
                            dau_pkg::MODE_ITERATION: r_state <= ST_POW1;
                            dau_pkg::MODE_GRADIENT:  r_state <= ST_GRD;
                            default:                 r_state <= ST_CRD;
                        endcase
                    end
                end
                ST_INIT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (&r_cnt[dau_pkg::NODE_W-1:0]) begin
                        r_res   <= r_val;
                        r_state <= ST_FIN;
                    end
                end
                ST_POW1: r_state <= ST_POW2;
                ST_POW2: begin
                    r_bp1   <= pow_t[32:16];
                    r_state <= ST_POW3;
                end
                ST_POW3: begin
                    r_bp2   <= pow_t[32:16];
                    r_iter  <= r_iter + 32'd1;
                    r_res   <= r_iter + 32'd1;
                    r_state <= ST_FIN;
                end
                ST_CRD: r_state <= ST_CACC;
                ST_CACC: begin
                    r_sum <= r_sum + 36'(signed'(r_nw_q));
                    if (cnt_next == r_cntn) begin
                        r_cnt   <= '0;
                        r_state <= ST_CDS;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= ST_CRD;
                    end
                end
                ST_CDS: r_state <= ST_CDW;
                ST_CDW: begin
                    if (div_rsp.done) begin
                        r_res   <= r_sum[35] ? -div_rsp.quotient[31:0]
                                             : div_rsp.quotient[31:0];
                        r_state <= ST_CWR;
                    end
                end
                ST_CWR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (cnt_next == r_cntn) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_GRD: r_state <= ST_G1;
                ST_G1:  r_state <= ST_G2;
                ST_G2: begin
                    r_acc   <= $signed(r_prod[49:0]);
                    r_state <= ST_G3;
                end
                ST_G3: begin
                    r_m     <= m_new;
                    r_state <= ST_G4;
                end
                ST_G4: begin
                    // The gradient square is never negative.
                    r_gsq   <= (|r_prod[63:47]) ? 31'h7FFFFFFF : r_prod[46:16];
                    r_state <= ST_G5;
                end
                ST_G5: begin
                    r_acc   <= $signed(r_prod[49:0]);
                    r_state <= ST_G6;
                end
                ST_G6: begin
                    r_v     <= v_new[31] ? 31'd0 : v_new[30:0];
                    r_state <= ST_G7;
                end
                ST_G7: begin
                    if (d1 == 17'd0) begin
                        r_mh    <= r_m;
                        r_state <= ST_G9;
                    end else begin
                        r_state <= ST_G8;
                    end
                end
                ST_G8: begin
                    if (div_rsp.done) begin
                        r_mh    <= dau_pkg::f_sat_quo(r_m[31], div_rsp.quotient);
                        r_state <= ST_G9;
                    end
                end
                ST_G9: begin
                    if (d2 == 17'd0) begin
                        r_vh    <= r_v;
                        r_state <= ST_SQI;
                    end else begin
                        r_state <= ST_G10;
                    end
                end
                ST_G10: begin
                    if (div_rsp.done) begin
                        r_vh    <= 31'(dau_pkg::f_sat_quo(1'b0, div_rsp.quotient));
                        r_state <= ST_SQI;
                    end
                end
                ST_SQI: begin
                    r_sx    <= {1'b0, r_vh, 16'b0};
                    r_sr    <= '0;
                    r_sb    <= 48'h4000_0000_0000;
                    r_cnt   <= '0;
                    r_state <= ST_SQL;
                end
                ST_SQL: begin
                    if (r_sx >= sq_t) begin
                        r_sx <= r_sx - sq_t;
                        r_sr <= (r_sr >> 1) + r_sb;
                    end else begin
                        r_sr <= r_sr >> 1;
                    end
                    r_sb  <= r_sb >> 2;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt[4:0] == 5'd23) begin
                        r_state <= ST_G13;
                    end
                end
                ST_G13: r_state <= ST_G14;
                ST_G14: begin
                    if (div_rsp.done) begin
                        r_dir   <= dau_pkg::f_sat_quo(r_mh[31], div_rsp.quotient);
                        r_state <= ST_G15;
                    end
                end
                ST_G15: r_state <= ST_G16;
                ST_G16: begin
                    r_delta <= delta_new;
                    r_state <= ST_G17;
                end
                ST_G17: begin
                    r_res   <= res_new;
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (fin_load) begin
                        r_okind  <= r_mode;
                        r_onode  <= (r_mode == dau_pkg::MODE_GRADIENT) ? r_node : '0;
                        r_oelem  <= (r_mode == dau_pkg::MODE_ITERATION) ? '0 : r_elem;
                        r_ovalue <= r_res;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tdata  = {4'b0, r_ovalue, r_oelem, r_onode};

    `DAU_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, r_state != ST_IDLE)
    `DAU_ASSERT_NOW(a_div_done_waited, i_clk, i_rst_n, div_rsp.done,
        r_state == ST_CDW || r_state == ST_G8 || r_state == ST_G10 || r_state == ST_G14)
    `DAU_ASSERT_NEXT(a_fin_loads_output, i_clk, i_rst_n,
        r_state == ST_FIN && !r_ovalid, m_axis_tvalid && r_state == ST_IDLE)
    `DAU_ASSERT_NOW(a_power_at_most_one, i_clk, i_rst_n, 1'b1,
        r_bp1 <= 17'h10000 && r_bp2 <= 17'h10000)

endmodule
